[rtl/sosg_pkg.sv]
// ----------------------------------------------------------------------------
// Sum-of-sinusoids generator package
// Shared widths, register indexes and sine polynomial constants.
// ----------------------------------------------------------------------------
package sosg_pkg;

  localparam int NumTerms = 5;
  localparam int RegCount = 8;
  localparam int CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] REG_OFFSET_SCALE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BIAS_GAIN    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MODE         = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TERM_BASE    = 3'd3;

  localparam logic [31:0] TURNS_PER_RAD = 32'd683565276;
  localparam logic [30:0] SIN_C1        = 31'd1686629713;
  localparam logic [30:0] SIN_C3        = 31'd693598669;
  localparam logic [30:0] SIN_C5        = 31'd85569306;
  localparam logic [30:0] SIN_C7        = 31'd4858526;
  localparam logic [30:0] Q30_ONE       = 31'd1073741824;

  // Configuration of one sine term.
  typedef struct packed {
    logic signed [31:0] amp;
    logic signed [15:0] freq;
    logic signed [15:0] phase;
  } term_cfg_t;

  // Common configuration shared by the front end and the term pipelines.
  typedef struct packed {
    logic signed [31:0] offset;
    logic signed [31:0] scale;
    logic signed [31:0] c0;
    logic signed [31:0] clin;
    logic               use_p;
    logic               half_turn;
  } core_cfg_t;

  // Saturate a 64-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    begin
      if (x > 64'sd2147483647) r = 32'sh7fffffff;
      else if (x < -64'sd2147483648) r = 32'sh80000000;
      else r = x[31:0];
      return r;
    end
  endfunction

endpackage

[rtl/sosg_term.sv]
// ----------------------------------------------------------------------------
// Sum-of-sinusoids term pipeline
// Computes amp*sin(angle) for one term from the argument p, eight stages.
// ----------------------------------------------------------------------------
module sosg_term (
  input  logic                        clk,
  input  logic signed [31:0]          p_in,
  input  logic                        half_turn,
  input  sosg_pkg::term_cfg_t         term_cfg,
  output logic signed [47:0]          term_out
);
  import sosg_pkg::*;

  // Stage 1: angle in Q.24.
  logic signed [48:0] a_r;
  always_ff @(posedge clk) begin
    a_r <= 49'(p_in) * 49'(term_cfg.freq) + 49'(signed'({term_cfg.phase, 12'd0}));
  end

  // Stage 2: turn phase, either a shift or the radian reduction product.
  // Only the product bits below 56 are needed, so the angle is split at bit 25
  // and the upper partial product is kept to 31 bits.
  logic [31:0] turn_r;
  logic [54:0] rad_lo;
  logic [30:0] rad_hi;
  logic [55:0] rad_sum;
  always_comb begin
    rad_lo  = 55'(a_r[24:0]) * 55'(TURNS_PER_RAD);
    rad_hi  = 31'(signed'(a_r[48:25])) * 31'(TURNS_PER_RAD);
    rad_sum = 56'(rad_lo) + {rad_hi, 25'd0};
  end
  always_ff @(posedge clk) begin
    if (half_turn) turn_r <= {a_r[24:0], 7'd0};
    else turn_r <= rad_sum[55:24];
  end

  // Stage 3: fold into the first quadrant and square.
  logic [30:0] x3_r;
  logic [1:0]  q3_r;
  logic [61:0] xx;
  logic [30:0] xf;
  always_comb begin
    xf = turn_r[30] ? (Q30_ONE - {1'b0, turn_r[29:0]}) : {1'b0, turn_r[29:0]};
    xx = 62'(xf) * 62'(xf);
  end
  logic [31:0] x2_r;
  always_ff @(posedge clk) begin
    x3_r <= xf;
    q3_r <= turn_r[31:30];
    x2_r <= xx[61:30];
  end

  // Stages 4 to 6: Horner steps of the odd polynomial.
  logic [30:0] x4_r, x5_r, x6_r;
  logic [1:0]  q4_r, q5_r, q6_r;
  logic [31:0] x2b_r, x2c_r;
  logic [30:0] t4_r, t5_r, t6_r;
  logic [62:0] m4, m5, m6;
  always_comb begin
    m4 = 63'(x2_r) * 63'(SIN_C7);
    m5 = 63'(x2b_r) * 63'(t4_r);
    m6 = 63'(x2c_r) * 63'(t5_r);
  end
  always_ff @(posedge clk) begin
    x4_r  <= x3_r;  q4_r <= q3_r;  x2b_r <= x2_r;
    t4_r  <= SIN_C5 - m4[60:30];
    x5_r  <= x4_r;  q5_r <= q4_r;  x2c_r <= x2b_r;
    t5_r  <= SIN_C3 - m5[60:30];
    x6_r  <= x5_r;  q6_r <= q5_r;
    t6_r  <= SIN_C1 - m6[60:30];
  end

  // Stage 7: final product, rounding to Q1.15 and sign.
  logic [61:0] m7;
  logic [31:0] y7;
  logic [16:0] s7;
  logic [15:0] sc7;
  logic signed [16:0] sin_r;
  always_comb begin
    m7  = 62'(x6_r) * 62'(t6_r);
    y7  = m7[61:30];
    s7  = 17'((33'(y7) + 33'd16384) >> 15);
    sc7 = (s7 > 17'd32767) ? 16'd32767 : s7[15:0];
  end
  always_ff @(posedge clk) begin
    sin_r <= q6_r[1] ? -17'(signed'({1'b0, sc7})) : 17'(signed'({1'b0, sc7}));
  end

  // Stage 8: amplitude product with floor shift.
  logic signed [48:0] ap;
  always_comb begin
    ap = 49'(term_cfg.amp) * 49'(sin_r);
  end
  always_ff @(posedge clk) begin
    term_out <= 48'(ap >>> 15);
  end

endmodule

[rtl/sosg_front.sv]
// ----------------------------------------------------------------------------
// Sum-of-sinusoids front end
// Offset removal, argument scaling and the linear term, three stages.
// ----------------------------------------------------------------------------
module sosg_front (
  input  logic                 clk,
  input  logic signed [31:0]   sample,
  input  sosg_pkg::core_cfg_t  cfg,
  output logic signed [31:0]   p_out,
  output logic signed [47:0]   lin_out
);
  import sosg_pkg::*;

  // Stage 1: offset removal.
  logic signed [31:0] d_r;
  always_ff @(posedge clk) begin
    d_r <= sat32(64'(sample) - 64'(cfg.offset));
  end

  // Stage 2: scaling.
  logic signed [63:0] dp;
  logic signed [31:0] d2_r;
  always_comb begin
    dp = 64'(d_r) * 64'(cfg.scale);
  end
  always_ff @(posedge clk) begin
    p_out <= sat32(dp >>> 16);
    d2_r  <= d_r;
  end

  // Stage 3: linear term with constant bias.
  logic signed [63:0] lp;
  always_comb begin
    lp = 64'(cfg.clin) * 64'(cfg.use_p ? p_out : d2_r);
  end
  always_ff @(posedge clk) begin
    lin_out <= 48'(lp >>> 16) + 48'(cfg.c0);
  end

endmodule

[rtl/sum_of_sinusoids_generator_unit.sv]
// ----------------------------------------------------------------------------
// Sum-of-sinusoids generator
// v = c0 + clin*x + sum of amp_i*sin(angle_i), with p and v*v alongside.
//
//  channel | ports                       | flow
//  --------+-----------------------------+-----------------------------
//  input   | start, busy, in_sample_in   | transfer when start & !busy
//  result  | out_valid, out_*            | one-cycle strobe, no stall
//  config  | cfg_we, cfg_index, cfg_data | write on cfg_we
//
// One sample enters every cycle; busy is always low. The result is
// registered through the front end, the sine term pipeline, the term
// adder tree and the square stages. Reset clears the valid line and
// the configuration registers to their reset values.
// ----------------------------------------------------------------------------
module sum_of_sinusoids_generator_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  in_sample_in,
  output logic                out_valid,
  output logic signed [31:0]  out_sum_out,
  output logic signed [31:0]  out_scaled_arg,
  output logic [62:0]         out_sum_squared,
  input  logic                cfg_we,
  input  logic [sosg_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0]         cfg_data
);
  import sosg_pkg::*;

  localparam int Lat = 14;

  // Configuration registers.
  logic [63:0] regs_r [RegCount];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RegCount; i++)
        regs_r[i] <= (i == int'(REG_OFFSET_SCALE)) ? 64'd65536 : 64'd0;
    end else if (cfg_we) begin
      if (cfg_index == REG_MODE) regs_r[cfg_index] <= {62'd0, cfg_data[1:0]};
      else regs_r[cfg_index] <= cfg_data;
    end
  end

  core_cfg_t cfg;
  always_comb begin
    cfg.offset    = regs_r[REG_OFFSET_SCALE][63:32];
    cfg.scale     = regs_r[REG_OFFSET_SCALE][31:0];
    cfg.c0        = regs_r[REG_BIAS_GAIN][63:32];
    cfg.clin      = regs_r[REG_BIAS_GAIN][31:0];
    cfg.use_p     = regs_r[REG_MODE][0];
    cfg.half_turn = regs_r[REG_MODE][1];
  end

  assign busy = 1'b0;

  // Valid line travels with the data.
  logic [Lat-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[Lat-2:0], start & ~busy};
  end

  // Front end.
  logic signed [31:0] p_s2;
  logic signed [47:0] lin_s3;
  sosg_front u_front (
    .clk(clk), .sample(in_sample_in), .cfg(cfg), .p_out(p_s2), .lin_out(lin_s3)
  );

  // Term pipelines, fed with p after stage 2.
  logic signed [47:0] term_v [NumTerms];
  for (genvar g = 0; g < NumTerms; g++) begin : g_term
    term_cfg_t tc;
    assign tc = regs_r[REG_TERM_BASE + CfgIdxW'(g)];
    sosg_term u_term (
      .clk(clk), .p_in(p_s2), .half_turn(cfg.half_turn),
      .term_cfg(tc), .term_out(term_v[g])
    );
  end

  // Delay p and the linear term to line up with the term outputs (stage 10).
  logic signed [31:0] p_d_r [8];
  logic signed [47:0] lin_d_r [7];
  always_ff @(posedge clk) begin
    p_d_r[0] <= p_s2;
    for (int i = 1; i < 8; i++) p_d_r[i] <= p_d_r[i-1];
    lin_d_r[0] <= lin_s3;
    for (int i = 1; i < 7; i++) lin_d_r[i] <= lin_d_r[i-1];
  end

  // Stage 11: partial sums.
  logic signed [47:0] sum_a_r, sum_b_r;
  logic signed [31:0] p11_r;
  always_ff @(posedge clk) begin
    logic signed [47:0] sa, sb;
    sa = lin_d_r[6];
    sb = '0;
    for (int i = 0; i < NumTerms; i++) begin
      if (i < 2) sa = sa + term_v[i];
      else sb = sb + term_v[i];
    end
    sum_a_r <= sa;
    sum_b_r <= sb;
    p11_r   <= p_d_r[7];
  end

  // Stage 12: final sum and saturation.
  logic signed [31:0] v12_r, p12_r;
  always_ff @(posedge clk) begin
    v12_r <= sat32(64'(sum_a_r) + 64'(sum_b_r));
    p12_r <= p11_r;
  end

  // Stages 13 and 14: square of v split in two 16-bit halves.
  logic [31:0] lo13_r;
  logic [31:0] hh13_r;
  logic [31:0] mid13_r;
  logic signed [31:0] v13_r, p13_r;
  logic [31:0] av;
  always_comb begin
    av = v12_r[31] ? 32'(-33'(v12_r)) : 32'(v12_r);
  end
  always_ff @(posedge clk) begin
    lo13_r  <= av[15:0] * av[15:0];
    hh13_r  <= av[31:16] * av[31:16];
    mid13_r <= av[31:16] * av[15:0];
    v13_r   <= v12_r;
    p13_r   <= p12_r;
  end
  always_ff @(posedge clk) begin
    out_sum_squared <= 63'({hh13_r, lo13_r} + (64'(mid13_r) << 17));
    out_sum_out     <= v13_r;
    out_scaled_arg  <= p13_r;
  end
  assign out_valid = vld_r[Lat-1];

`ifndef NO_ASSERTIONS
  a_busy_low: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##Lat out_valid)
    else $error("result lost");
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, Lat))
    else $error("result invented");
`endif

endmodule
